### sv/vvdd_pkg.sv
// Shared types and constants for the velocity vector to diff-drive converter.
package vvdd_pkg;

    localparam int unsigned CFG_W = 15;
    localparam int unsigned ANG_W = 20;
    localparam int unsigned VEC_W = 36;
    localparam int unsigned COS_W = 34;

    localparam logic signed [ANG_W-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [COS_W-1:0] INV_GAIN_Q30 = 34'sd652032875;

    localparam logic [2:0] REG_TURN_RATE = 3'd0;
    localparam logic [2:0] REG_ACCEL     = 3'd1;
    localparam logic [2:0] REG_DECEL     = 3'd2;
    localparam logic [2:0] REG_DEADBAND  = 3'd3;
    localparam logic [2:0] REG_MIN_SPEED = 3'd4;

    localparam logic FUNC_VECTOR = 1'b0;
    localparam logic FUNC_DIRECT = 1'b1;

    // One classified request passed from front to back
    typedef struct packed {
        logic               direct;
        logic               zero_vec;
        logic               vy_zero;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] direct_turn;
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_YAW_MUL, ST_HDG_INIT, ST_HDG_RUN, ST_MAG_MUL,
        ST_YAW_INIT, ST_YAW_RUN, ST_DIFF, ST_COS_RUN, ST_PROJ,
        ST_SLEW, ST_OUT
    } state_t;

    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0:  atan_q16 = 20'sd51472;
            5'd1:  atan_q16 = 20'sd30386;
            5'd2:  atan_q16 = 20'sd16055;
            5'd3:  atan_q16 = 20'sd8150;
            5'd4:  atan_q16 = 20'sd4091;
            5'd5:  atan_q16 = 20'sd2047;
            5'd6:  atan_q16 = 20'sd1024;
            5'd7:  atan_q16 = 20'sd512;
            5'd8:  atan_q16 = 20'sd256;
            5'd9:  atan_q16 = 20'sd128;
            5'd10: atan_q16 = 20'sd64;
            5'd11: atan_q16 = 20'sd32;
            5'd12: atan_q16 = 20'sd16;
            5'd13: atan_q16 = 20'sd8;
            5'd14: atan_q16 = 20'sd4;
            5'd15: atan_q16 = 20'sd2;
            5'd16: atan_q16 = 20'sd1;
            default: atan_q16 = '0;
        endcase
    endfunction

endpackage

### sv/vvdd_front.sv
// Front end: accepts requests, classifies them, holds a two-entry queue.
module vvdd_front
    import vvdd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         s_tuser,
    output logic         q_valid,
    input  logic         q_pop,
    output req_t         q_req
);
    req_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    req_t       in_req;
    logic       push;

    // Field unpack and classification
    always_comb begin
        in_req.direct      = (s_tuser == FUNC_DIRECT);
        in_req.vel_x       = s_tdata[15:0];
        in_req.vel_y       = s_tdata[31:16];
        in_req.quat_w      = s_tdata[47:32];
        in_req.quat_x      = s_tdata[63:48];
        in_req.quat_y      = s_tdata[79:64];
        in_req.quat_z      = s_tdata[95:80];
        in_req.direct_turn = s_tdata[111:96];
        in_req.vy_zero     = (s_tdata[31:16] == 16'd0);
        in_req.zero_vec    = in_req.vy_zero && (s_tdata[15:0] == 16'd0);
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

### sv/vvdd_back.sv
// Back end: sequencer with a shared CORDIC angle table, projection and slew.
module vvdd_back
    import vvdd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  req_t               q_req,
    input  logic [CFG_W-1:0]   turn_rate,
    input  logic [CFG_W-1:0]   accel_step,
    input  logic [CFG_W-1:0]   decel_step,
    input  logic [CFG_W-1:0]   heading_deadband,
    input  logic [CFG_W-1:0]   min_speed,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata
);
    state_t state_reg, state_next;
    req_t   req_reg;
    logic [4:0] it_reg;
    logic signed [VEC_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0] z_reg, heading_reg, diff_reg;
    logic signed [COS_W-1:0] cx_reg, cy_reg;
    logic neg_reg;
    logic signed [34:0] yx_reg, yy_reg;
    logic signed [33:0] ww_reg;
    logic signed [17:0] speed_reg;
    logic signed [17:0] target_reg;
    logic signed [15:0] smooth_reg, lin_reg, ang_reg;
    logic [31:0] out_reg;
    logic out_valid_reg;

    logic last_it;
    logic signed [VEC_W-1:0] xs, ys;
    logic signed [COS_W-1:0] cxs, cys;
    logic signed [ANG_W-1:0] at;
    logic signed [52:0] mag_prod;
    logic signed [52:0] proj_prod;
    logic signed [ANG_W+5:0] db;
    logic signed [17:0] goal, lim, cand;
    logic signed [ANG_W:0] d0;

    assign last_it = (it_reg == 5'(CORDIC_STEPS - 1));
    assign xs  = x_reg >>> it_reg;
    assign ys  = y_reg >>> it_reg;
    assign cxs = cx_reg >>> it_reg;
    assign cys = cy_reg >>> it_reg;
    assign at  = atan_q16(it_reg);
    assign mag_prod  = 53'(x_reg) * $signed({1'b0, INV_GAIN_Q16});
    assign proj_prod = 53'(speed_reg) * 53'(cx_reg);
    assign db = $signed({7'd0, heading_deadband, 4'd0});
    assign d0 = 21'(z_reg) - 21'(heading_reg);
    assign goal = 18'((proj_prod + (53'sd1 <<< 29)) >>> 30);

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (q_valid) state_next = ST_YAW_MUL;
            ST_YAW_MUL: begin
                if (req_reg.direct || req_reg.zero_vec) state_next = ST_SLEW;
                else state_next = ST_HDG_INIT;
            end
            ST_HDG_INIT: state_next = ST_HDG_RUN;
            ST_HDG_RUN:  if (last_it) state_next = ST_MAG_MUL;
            ST_MAG_MUL:  state_next = ST_YAW_INIT;
            ST_YAW_INIT: state_next = ST_YAW_RUN;
            ST_YAW_RUN:  if (last_it) state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_COS_RUN;
            ST_COS_RUN:  if (last_it) state_next = ST_PROJ;
            ST_PROJ:     state_next = ST_SLEW;
            ST_SLEW:     state_next = ST_OUT;
            ST_OUT:      if (out_valid_reg && m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                req_reg <= q_req;
                it_reg  <= '0;
            end
            ST_YAW_MUL: begin
                yx_reg <= 35'(req_reg.quat_z) * 35'(req_reg.quat_z)
                        + 35'(req_reg.quat_y) * 35'(req_reg.quat_y);
                yy_reg <= 35'(req_reg.quat_w) * 35'(req_reg.quat_z)
                        + 35'(req_reg.quat_x) * 35'(req_reg.quat_y);
                target_reg <= 18'(req_reg.vel_x);
                ww_reg <= '0;
            end
            ST_HDG_INIT, ST_YAW_INIT: begin
                logic signed [VEC_W-1:0] vx, vy;
                if (state_reg == ST_HDG_INIT) begin
                    vx = VEC_W'(req_reg.vel_x) <<< 8;
                    vy = VEC_W'(req_reg.vel_y) <<< 8;
                end else begin
                    vx = (VEC_W'(1) <<< 24) - (VEC_W'(yx_reg) <<< 1);
                    vy = VEC_W'(yy_reg) <<< 1;
                end
                it_reg <= '0;
                if (vx < 0) begin
                    if (vy >= 0) begin
                        x_reg <= vy; y_reg <= -vx; z_reg <= HALF_PI_Q16;
                    end else begin
                        x_reg <= -vy; y_reg <= vx; z_reg <= -HALF_PI_Q16;
                    end
                end else begin
                    x_reg <= vx; y_reg <= vy; z_reg <= '0;
                end
                if (vx == 0 && vy == 0) begin
                    x_reg <= '0; y_reg <= '0; z_reg <= '0;
                    ww_reg <= 34'sd1;
                end else begin
                    ww_reg <= '0;
                end
            end
            ST_HDG_RUN, ST_YAW_RUN: begin
                it_reg <= it_reg + 5'd1;
                if (ww_reg == 0) begin
                    if (y_reg > 0) begin
                        x_reg <= x_reg + ys; y_reg <= y_reg - xs; z_reg <= z_reg + at;
                    end else begin
                        x_reg <= x_reg - ys; y_reg <= y_reg + xs; z_reg <= z_reg - at;
                    end
                end
                if (last_it && state_reg == ST_HDG_RUN) begin
                    heading_reg <= req_reg.vy_zero ? '0 :
                        ((ww_reg == 0) ? ((y_reg > 0) ? z_reg + at : z_reg - at) : '0);
                end
            end
            ST_MAG_MUL: begin
                speed_reg <= 18'((mag_prod + (53'sd1 <<< 23)) >>> 24);
            end
            ST_DIFF: begin
                logic signed [ANG_W+1:0] d;
                logic signed [ANG_W+1:0] c;
                d = 22'(d0);
                if (d > 22'(PI_Q16)) d = d - 22'(PI_Q16) - 22'(PI_Q16);
                else if (d < -22'(PI_Q16)) d = d + 22'(PI_Q16) + 22'(PI_Q16);
                diff_reg <= ANG_W'(d);
                c = d;
                neg_reg <= 1'b0;
                if (d > 22'(HALF_PI_Q16)) begin
                    c = d - 22'(PI_Q16); neg_reg <= 1'b1;
                end else if (d < -22'(HALF_PI_Q16)) begin
                    c = d + 22'(PI_Q16); neg_reg <= 1'b1;
                end
                z_reg  <= ANG_W'(c);
                cx_reg <= INV_GAIN_Q30;
                cy_reg <= '0;
                it_reg <= '0;
            end
            ST_COS_RUN: begin
                it_reg <= it_reg + 5'd1;
                if (z_reg >= 0) begin
                    cx_reg <= cx_reg - cys; cy_reg <= cy_reg + cxs; z_reg <= z_reg - at;
                end else begin
                    cx_reg <= cx_reg + cys; cy_reg <= cy_reg - cxs; z_reg <= z_reg + at;
                end
                if (last_it && neg_reg) begin
                    cx_reg <= -((z_reg >= 0) ? cx_reg - cys : cx_reg + cys);
                end
            end
            ST_PROJ: begin
                target_reg <= (goal < $signed({3'd0, min_speed})) ? '0 : goal;
                if (diff_reg > db)
                    ang_reg <= (diff_reg < PI_Q16) ? -$signed({1'b0, turn_rate})
                                                   : $signed({1'b0, turn_rate});
                else if (diff_reg < -db)
                    ang_reg <= (diff_reg < -PI_Q16) ? -$signed({1'b0, turn_rate})
                                                    : $signed({1'b0, turn_rate});
                else
                    ang_reg <= '0;
            end
            ST_SLEW: begin
                if (req_reg.direct) begin
                    lin_reg <= cand[15:0];
                    ang_reg <= req_reg.direct_turn;
                end else if (req_reg.zero_vec) begin
                    lin_reg <= '0;
                    ang_reg <= '0;
                end else begin
                    lin_reg <= cand[15:0];
                end
            end
            default: ;
        endcase
    end

    // Slew limit against the stored speed, with saturation
    always_comb begin
        lim  = 18'(smooth_reg);
        cand = 18'(smooth_reg);
        if (target_reg > 18'(smooth_reg)) begin
            lim  = 18'(smooth_reg) + $signed({3'd0, accel_step});
            cand = (target_reg < lim) ? target_reg : lim;
        end else if (target_reg < 18'(smooth_reg)) begin
            lim  = 18'(smooth_reg) - $signed({3'd0, decel_step});
            cand = (target_reg > lim) ? target_reg : lim;
        end
        if (cand > 18'sd32767) cand = 18'sd32767;
        else if (cand < -18'sd32768) cand = -18'sd32768;
    end

    // Stored speed and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_SLEW && !(req_reg.zero_vec && !req_reg.direct))
                smooth_reg <= cand[15:0];
            if (state_reg == ST_OUT && !out_valid_reg)
                out_valid_reg <= 1'b1;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SLEW) out_reg <= '0;
        if (state_reg == ST_OUT) out_reg <= {ang_reg, lin_reg};
    end
endmodule

### sv/velocity_vector_to_diff_drive.sv
// Top level: configuration registers, front end queue and CORDIC back end.
// Vector requests run through the CORDIC loop for heading, yaw and cosine;
// direct or zero requests skip it and go from the yaw multiply to the slew state.
// Throughput: one request at a time through the back end; a two-entry queue
// accepts further requests meanwhile. Reset (aresetn, synchronous, active low)
// loads register defaults and clears the stored speed and all control state.
module velocity_vector_to_diff_drive
    import vvdd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // vel_x, vel_y, quat_w, quat_x, quat_y, quat_z, direct_turn
    input  logic         s_tuser,  // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // linear_cmd, angular_cmd
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [14:0]  cfg_wdata
);
    logic [CFG_W-1:0] turn_rate_reg, accel_reg, decel_reg, deadband_reg, min_speed_reg;
    logic q_valid, q_pop;
    req_t q_req;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_rate_reg <= 15'd8192;
            accel_reg     <= 15'd205;
            decel_reg     <= 15'd205;
            deadband_reg  <= 15'd410;
            min_speed_reg <= 15'd41;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TURN_RATE: turn_rate_reg <= cfg_wdata;
                REG_ACCEL:     accel_reg     <= cfg_wdata;
                REG_DECEL:     decel_reg     <= cfg_wdata;
                REG_DEADBAND:  deadband_reg  <= cfg_wdata;
                REG_MIN_SPEED: min_speed_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vvdd_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid, .q_pop, .q_req
    );

    vvdd_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk, .aresetn, .q_valid, .q_pop, .q_req,
        .turn_rate(turn_rate_reg), .accel_step(accel_reg), .decel_step(decel_reg),
        .heading_deadband(deadband_reg), .min_speed(min_speed_reg),
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule
